>>> hdl/crc8_crc16_byte_engine_core_macros.svh
// ----------------------------------------------------------------------------
// crc8_crc16_byte_engine_core_macros.svh
// Assertion macros used by the CRC byte engine checker.
// ----------------------------------------------------------------------------
`ifndef CRC8_CRC16_BYTE_ENGINE_CORE_MACROS_SVH
`define CRC8_CRC16_BYTE_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CRCBE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("crcbe assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CRCBE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("crcbe assertion failed");

`endif

>>> hdl/crcbe_pkg.sv
// ----------------------------------------------------------------------------
// crcbe_pkg
// Types, codes and CRC fold functions for the CRC-8 / CRC-16 byte engine.
// ----------------------------------------------------------------------------
package crcbe_pkg;

	// Mode codes
	localparam logic [1:0] MODE_CRC8  = 2'd0;
	localparam logic [1:0] MODE_CRC16 = 2'd1;
	localparam logic [1:0] MODE_PAIR  = 2'd2;

	// Register indexes
	localparam logic [1:0] CFG_MODE   = 2'd0;
	localparam logic [1:0] CFG_SEED   = 2'd1;
	localparam logic [1:0] CFG_PREFIX = 2'd2;

	localparam logic [7:0]  POLY8      = 8'h2F;
	localparam logic [15:0] POLY16     = 16'h1021;
	localparam logic [15:0] PAIR_INIT  = 16'h1D0F;
	localparam logic [15:0] SEED_ONES  = 16'hFFFF;

	// Running message state
	typedef struct packed {
		logic [15:0] crc;
		logic [7:0]  held;
		logic        phase;
		logic        open;
	} crcbe_state_t;

	// One byte through CRC-8, MSB first
	function automatic logic [7:0] fold8(input logic [7:0] c, input logic [7:0] b);
		logic [7:0] v;
		v = c ^ b;
		for (int k = 0; k < 8; k++) begin
			v = v[7] ? ({v[6:0], 1'b0} ^ POLY8) : {v[6:0], 1'b0};
		end
		return v;
	endfunction

	// One byte through CRC-16, MSB first
	function automatic logic [15:0] fold16(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] v;
		v = c ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			v = v[15] ? ({v[14:0], 1'b0} ^ POLY16) : {v[14:0], 1'b0};
		end
		return v;
	endfunction

	// Small seeds (1 to 8) in pair mode are scaled by the polynomial; all-ones maps to PAIR_INIT
	function automatic logic [15:0] pair_seed(input logic [15:0] seed);
		logic [15:0] r;
		case (seed)
			16'd1: r = 16'h1021;
			16'd2: r = 16'h2042;
			16'd3: r = 16'h3063;
			16'd4: r = 16'h4084;
			16'd5: r = 16'h50A5;
			16'd6: r = 16'h60C6;
			16'd7: r = 16'h70E7;
			16'd8: r = 16'h8108;
			SEED_ONES: r = PAIR_INIT;
			default: r = seed;
		endcase
		return r;
	endfunction

	// CRC value at message start
	function automatic logic [15:0] start_value(input logic [1:0] mode,
			input logic [15:0] seed, input logic prefix);
		logic [15:0] c;
		case (mode)
			MODE_CRC8: begin
				c = {8'h00, seed[7:0]};
				if (prefix) begin
					c = {8'h00, fold8(seed[7:0], 8'h00)};
				end
			end
			MODE_PAIR: c = pair_seed(seed);
			default: begin
				c = seed;
				if (prefix) begin
					c = fold16(fold16(seed, 8'h00), 8'h00);
				end
			end
		endcase
		return c;
	endfunction

endpackage

>>> hdl/crcbe_step.sv
// ----------------------------------------------------------------------------
// crcbe_step
// Folds one message byte into the running state and forms the result value.
// ----------------------------------------------------------------------------
module crcbe_step
	import crcbe_pkg::*;
(
	input  logic [1:0]   mode,
	input  logic [15:0]  seed,
	input  logic         prefix,
	input  crcbe_state_t cur,
	input  logic [7:0]   data_byte,
	input  logic         last_byte,
	output crcbe_state_t nxt,
	output logic [15:0]  result
);

	logic [15:0] base;
	logic        phase_b;
	logic [15:0] crc_n;

	// Start of message reloads from the seed
	assign base    = cur.open ? cur.crc : start_value(mode, seed, prefix);
	assign phase_b = cur.open & cur.phase;

	always_comb begin
		nxt   = cur;
		crc_n = base;
		case (mode)
			MODE_CRC8: begin
				crc_n = {8'h00, fold8(base[7:0], data_byte)};
				nxt.phase = phase_b;
			end
			MODE_PAIR: begin
				if (!phase_b) begin
					nxt.held  = data_byte;
					nxt.phase = 1'b1;
				end else begin
					crc_n     = fold16(fold16(base, data_byte), cur.held);
					nxt.phase = 1'b0;
				end
			end
			default: begin
				crc_n = fold16(base, data_byte);
				nxt.phase = phase_b;
			end
		endcase
		nxt.crc  = crc_n;
		nxt.open = ~last_byte;
		if (last_byte) begin
			nxt.phase = 1'b0;
		end
		result = (mode == MODE_CRC8) ? {8'h00, crc_n[7:0]} : crc_n;
	end

endmodule

>>> hdl/crc8_crc16_byte_engine_core.sv
// ----------------------------------------------------------------------------
// crc8_crc16_byte_engine_core
// CRC-8 (poly 0x2F) / CRC-16 (poly 0x1021) engine, one message byte per beat.
// ----------------------------------------------------------------------------
// A last beat passes the input register and then the result register before its CRC shows on the output.
// Throughput: one byte per clock while no last byte waits on a full result register; the
// byte fold is a single pass of logic between the input register and the state/result registers.
// The input stage holds a last byte only while the result register is full.
// Reset: arst_n clears the pipeline, message state and registers to
// mode 0, seed 0xFFFF, no zero prefix.
module crc8_crc16_byte_engine_core
	import crcbe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] crc_value
);

	logic [1:0]   mode_q;
	logic [15:0]  seed_q;
	logic         prefix_q;

	logic         valid_s1;
	logic [7:0]   data_s1;
	logic         last_s1;

	logic [15:0]  crc_q;
	logic         phase_q;
	logic         open_q;
	logic [7:0]   held_q;
	crcbe_state_t cur;
	crcbe_state_t nxt;
	logic [15:0]  result;

	logic         out_valid_q;
	logic [15:0]  crc_value_q;
	logic         advance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_CRC8;
			seed_q   <= SEED_ONES;
			prefix_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MODE:   mode_q   <= cfg_data[1:0];
				CFG_SEED:   seed_q   <= cfg_data;
				CFG_PREFIX: prefix_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// A stage-1 beat moves on unless it ends a message and the result slot is full and unread
	assign advance  = valid_s1 & (~last_s1 | ~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready & in_valid) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	assign cur = '{crc: crc_q, held: held_q, phase: phase_q, open: open_q};

	crcbe_step u_step (
		.mode      (mode_q),
		.seed      (seed_q),
		.prefix    (prefix_q),
		.cur       (cur),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.nxt       (nxt),
		.result    (result)
	);

	// Message state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= '0;
			phase_q <= 1'b0;
			open_q  <= 1'b0;
		end else if (advance) begin
			crc_q   <= nxt.crc;
			phase_q <= nxt.phase;
			open_q  <= nxt.open;
		end
	end

	// Held even byte of a pair, never read before written
	always_ff @(posedge clk) begin
		if (advance) begin
			held_q <= nxt.held;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance & last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance & last_s1) begin
			crc_value_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign crc_value = crc_value_q;

endmodule

>>> hdl/crcbe_checker.sv
// ----------------------------------------------------------------------------
// crcbe_checker
// Port-level checks on the CRC byte engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "crc8_crc16_byte_engine_core_macros.svh"

module crcbe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        last_byte,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] crc_value
);

	// A stalled result beat holds its value
	`CRCBE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(crc_value))

	// With the result slot empty the input side never stalls
	`CRCBE_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)

	// A last beat reaches the output through the input and result registers when the slot is free
	`CRCBE_ASSERT_NEXT(a_last_to_out, (in_valid && in_ready && last_byte) ##1 !out_valid, out_valid)

endmodule

bind crc8_crc16_byte_engine_core crcbe_checker u_crcbe_checker (.*);

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the CRC-8 / CRC-16 byte engine.
// A byte-level model predicts the CRC of every message as its last beat is
// accepted. Each CRC that leaves the block is checked against the oldest
// prediction. A few directed messages cover all modes, seed mappings, zero
// prefix, odd pair tails and mode switches inside a message. Random messages
// with random register settings follow, under three patterns of idle cycles
// on the input and output sides.
// ----------------------------------------------------------------------------
module tb;
	import crcbe_pkg::*;

	// The encoding that is not a named mode; the block runs it as CRC-16
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 300000;
	// Cycles to let the pipeline empty before a register write
	localparam int SETTLE_CYCLES = 4;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_MODE;
	logic [15:0] cfg_data = 16'h0000;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] crc_value;

	// Register copies
	logic [1:0]  mode_q = MODE_CRC8;
	logic [15:0] seed_q = 16'hFFFF;
	logic        prefix_q = 1'b0;

	// Message state of the model
	logic [15:0] crc_acc = 16'h0000;
	logic [7:0]  even_byte = 8'h00;
	logic        pair_odd = 1'b0;
	logic        msg_open = 1'b0;

	logic [15:0] expected_crcs[$];
	int          errors = 0;
	int          cycles = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;

	crc8_crc16_byte_engine_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.crc_value (crc_value)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Model
	// ------------------------------------------------------------------

	// CRC-8 over one byte, MSB first; upper byte of the result is zero
	function automatic logic [15:0] crc8_byte(input logic [15:0] c, input logic [7:0] b);
		logic [7:0] v;
		v = c[7:0] ^ b;
		for (int k = 0; k < 8; k++) begin
			if (v[7]) begin
				v = {v[6:0], 1'b0} ^ POLY8;
			end else begin
				v = {v[6:0], 1'b0};
			end
		end
		return {8'h00, v};
	endfunction

	// CRC-16 over one byte, MSB first
	function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] v;
		v = c ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (v[15]) begin
				v = {v[14:0], 1'b0} ^ POLY16;
			end else begin
				v = {v[14:0], 1'b0};
			end
		end
		return v;
	endfunction

	// CRC at the first byte of a message
	function automatic logic [15:0] initial_crc(input logic [1:0] mode);
		logic [15:0] c;
		case (mode)
			MODE_CRC8: begin
				c = {8'h00, seed_q[7:0]};
				if (prefix_q) begin
					c = crc8_byte(c, 8'h00);
				end
			end
			MODE_PAIR: begin
				if (seed_q == 16'hFFFF) begin
					c = PAIR_INIT;
				end else if (seed_q >= 16'd1 && seed_q <= 16'd8) begin
					c = seed_q * POLY16;
				end else begin
					c = seed_q;
				end
			end
			default: begin
				c = seed_q;
				if (prefix_q) begin
					c = crc16_byte(crc16_byte(c, 8'h00), 8'h00);
				end
			end
		endcase
		return c;
	endfunction

	// Fold one accepted beat; a last beat queues the finished CRC
	task automatic fold_beat(input logic [7:0] b, input logic last);
		logic [1:0] mode;
		mode = mode_q;
		if (!msg_open) begin
			crc_acc = initial_crc(mode);
			pair_odd = 1'b0;
			msg_open = 1'b1;
		end
		case (mode)
			MODE_CRC8: crc_acc = crc8_byte(crc_acc, b);
			MODE_PAIR: begin
				if (!pair_odd) begin
					even_byte = b;
					pair_odd = 1'b1;
				end else begin
					crc_acc = crc16_byte(crc16_byte(crc_acc, b), even_byte);
					pair_odd = 1'b0;
				end
			end
			default: crc_acc = crc16_byte(crc_acc, b);
		endcase
		if (last) begin
			if (mode == MODE_CRC8) begin
				expected_crcs.push_back({8'h00, crc_acc[7:0]});
			end else begin
				expected_crcs.push_back(crc_acc);
			end
			msg_open = 1'b0;
			pair_odd = 1'b0;
		end
	endtask

	// ------------------------------------------------------------------
	// Beat monitor and result check
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		logic [15:0] want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				fold_beat(data_byte, last_byte);
			end
			if (out_valid && out_ready) begin
				if (expected_crcs.size() == 0) begin
					$error("crc_value: unexpected result, expected none, actual %h", crc_value);
					errors++;
				end else begin
					want = expected_crcs.pop_front();
					if (crc_value !== want) begin
						$error("crc_value: expected %h, actual %h", want, crc_value);
						errors++;
					end
				end
			end
		end
	end

	// Output side back-pressure
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// Present one beat after random idle cycles; returns at the accepting edge
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= last;
		@(posedge clk);
		while (!(in_valid && in_ready)) begin
			@(posedge clk);
		end
	endtask

	// Hold off input until every CRC is out and the pipeline is empty
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_crcs.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all three registers; only called while the block is idle
	task automatic set_regs(input logic [1:0] mode, input logic [15:0] seed,
			input logic prefix);
		mode_q = mode;
		seed_q = seed;
		prefix_q = prefix;
		cfg_we <= 1'b1;
		cfg_index <= CFG_MODE;
		cfg_data <= {14'h0000, mode};
		@(posedge clk);
		cfg_index <= CFG_SEED;
		cfg_data <= seed;
		@(posedge clk);
		cfg_index <= CFG_PREFIX;
		cfg_data <= {15'h0000, prefix};
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [1:0] pick_mode();
		int r;
		r = $urandom_range(99);
		if (r < 6) begin
			return MODE_SPARE;
		end else if (r < 37) begin
			return MODE_CRC8;
		end else if (r < 68) begin
			return MODE_CRC16;
		end
		return MODE_PAIR;
	endfunction

	function automatic logic [15:0] pick_seed();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(1, 8));
			3: return 16'hFFFE;
			4: return 16'h0009;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_byte();
		if ($urandom_range(9) == 0) begin
			case ($urandom_range(3))
				0: return 8'h00;
				1: return 8'hFF;
				2: return 8'h80;
				default: return 8'h01;
			endcase
		end
		return 8'($urandom);
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Register values after reset: CRC-8, seed low byte 0xFF, no prefix
	task automatic test_reset_defaults();
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
	endtask

	// Seeds at their extremes and in between, with and without zero prefix, modes 0, 1, 3
	task automatic test_seed_and_prefix();
		settle();
		set_regs(MODE_CRC8, 16'h1234, 1'b1);
		send_byte(8'hA5, 1'b0);
		send_byte(8'h5A, 1'b1);
		settle();
		set_regs(MODE_CRC16, 16'h0000, 1'b1);
		send_byte(8'hFF, 1'b1);
		settle();
		set_regs(MODE_CRC16, 16'hFFFF, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h01, 1'b1);
		settle();
		set_regs(MODE_SPARE, 16'hABCD, 1'b1);
		send_byte(8'h3C, 1'b1);
	endtask

	// Byte pairs: seed mapping, single byte, dropped odd tail, plain seed
	task automatic test_pair_mode();
		settle();
		set_regs(MODE_PAIR, 16'hFFFF, 1'b1);
		send_byte(8'h31, 1'b0);
		send_byte(8'h32, 1'b0);
		send_byte(8'h33, 1'b0);
		send_byte(8'h34, 1'b1);
		settle();
		set_regs(MODE_PAIR, 16'h0008, 1'b0);
		send_byte(8'h77, 1'b1);
		settle();
		set_regs(MODE_PAIR, 16'h0001, 1'b0);
		send_byte(8'h12, 1'b0);
		send_byte(8'h34, 1'b0);
		send_byte(8'h56, 1'b1);
		settle();
		set_regs(MODE_PAIR, 16'h0009, 1'b0);
		send_byte(8'hFE, 1'b0);
		send_byte(8'hEF, 1'b1);
	endtask

	// Mode changes while a message is open, with a held pair byte across them
	task automatic test_mode_switch();
		settle();
		set_regs(MODE_CRC16, 16'h5555, 1'b0);
		send_byte(8'hC3, 1'b0);
		settle();
		set_regs(MODE_PAIR, 16'h5555, 1'b0);
		send_byte(8'h11, 1'b0);
		settle();
		set_regs(MODE_CRC8, 16'h5555, 1'b0);
		send_byte(8'h22, 1'b0);
		settle();
		set_regs(MODE_PAIR, 16'h5555, 1'b0);
		send_byte(8'h33, 1'b1);
	endtask

	// Random messages with random settings between them and, rarely, a random mode inside them
	task automatic test_random(input int n_beats, input int send_pct, input int recv_pct);
		int sent;
		int len;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		sent = 0;
		while (sent < n_beats) begin
			if ($urandom_range(99) < 30) begin
				settle();
				set_regs(pick_mode(), pick_seed(), 1'($urandom_range(1)));
			end
			if ($urandom_range(9) == 0) begin
				len = $urandom_range(13, 40);
			end else begin
				len = $urandom_range(1, 12);
			end
			for (int i = 0; i < len; i++) begin
				if (i > 0 && $urandom_range(99) < 3) begin
					settle();
					set_regs(pick_mode(), seed_q, prefix_q);
				end
				send_byte(pick_byte(), i == len - 1);
				sent++;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_seed_and_prefix();
		test_pair_mode();
		test_mode_switch();
		test_random(610, 37, 71);
		test_random(610, 71, 37);
		test_random(610, 0, 0);

		// Drain, then give the block time to show any stray result
		in_valid <= 1'b0;
		@(posedge clk);
		for (int k = 0; k < 5000 && expected_crcs.size() != 0; k++) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_crcs.size() != 0) begin
			$error("crc_value: %0d expected results never arrived", expected_crcs.size());
			errors++;
		end

		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

>>> crc8_crc16_byte_engine_core.f
+incdir+hdl
hdl/crcbe_pkg.sv
hdl/crcbe_step.sv
hdl/crc8_crc16_byte_engine_core.sv
hdl/crcbe_checker.sv
tb/tb.sv
